/* rtl/pqp_pkg.sv */
`default_nettype none
package pqp_pkg;

    // Palette size and the index width that addresses it
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Squared RGB distance: three 16-bit squares summed
    localparam int DIST_W = 18;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Depth mode codes; the unused code behaves as eight-bit indices
    localparam logic [1:0] DEPTH_1B    = 2'd0;
    localparam logic [1:0] DEPTH_4B    = 2'd1;
    localparam logic [1:0] DEPTH_8B    = 2'd2;
    localparam logic [1:0] DEPTH_RESET = DEPTH_8B;

    // Register indexes
    localparam logic REG_DEPTH_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Request from the control side to the search unit
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_rgb             wr_data;
        logic             start;
        t_rgb             pixel;
        logic [IDX_W-1:0] last;
    } t_search_req;

    // Result of one search
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] idx;
    } t_search_rsp;

    // Highest palette index searched in a depth mode
    function automatic logic [IDX_W-1:0] active_last(input logic [1:0] mode);
        int n;
        case (mode)
            DEPTH_1B: n = 2;
            DEPTH_4B: n = 16;
            default:  n = 256;
        endcase
        if (n > PALETTE_ENTRIES) n = PALETTE_ENTRIES;
        return IDX_W'(n - 1);
    endfunction

endpackage
`default_nettype wire

/* rtl/pqp_if.sv */
`default_nettype none
// Command channel into the quantizer
interface pqp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;

    modport source (output valid, command, entry_index, red, green, blue, row_end,
                    input ready);
    modport sink   (input valid, command, entry_index, red, green, blue, row_end,
                    output ready);
endinterface

// Packed byte channel out of the quantizer
interface pqp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       row_done;

    modport source (output valid, packed_byte, row_done, input ready);
    modport sink   (input valid, packed_byte, row_done, output ready);
endinterface
`default_nettype wire

/* rtl/pqp_search.sv */
`default_nettype none
module pqp_search import pqp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_search_req i_req,
    output t_search_rsp o_rsp
);

    // Palette memory, one read port with registered data
    t_rgb r_mem [PALETTE_ENTRIES];
    t_rgb r_rd_data;

    logic             r_issue;
    logic [IDX_W-1:0] r_rd_addr;
    logic [IDX_W-1:0] r_last;
    t_rgb             r_pixel;

    logic             r_s1_vld;
    logic [IDX_W-1:0] r_s1_idx;

    logic             r_s2_vld;
    logic [IDX_W-1:0] r_s2_idx;
    logic [15:0]      r_sq_r;
    logic [15:0]      r_sq_g;
    logic [15:0]      r_sq_b;

    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;

    logic             r_done;
    logic [IDX_W-1:0] r_idx;

    logic [7:0]        d_r;
    logic [7:0]        d_g;
    logic [7:0]        d_b;
    logic [DIST_W-1:0] dist_sum;
    logic              better;
    logic              fin;
    logic [IDX_W-1:0]  fin_idx;

    // Write entries and read one entry per cycle while the sweep runs
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) r_mem[i_req.wr_addr] <= i_req.wr_data;
        if (r_issue)     r_rd_data <= r_mem[r_rd_addr];
    end

    // Absolute channel differences against the latched pixel
    always_comb begin
        d_r = (r_rd_data.red > r_pixel.red) ? r_rd_data.red - r_pixel.red
                                            : r_pixel.red - r_rd_data.red;
        d_g = (r_rd_data.green > r_pixel.green) ? r_rd_data.green - r_pixel.green
                                                : r_pixel.green - r_rd_data.green;
        d_b = (r_rd_data.blue > r_pixel.blue) ? r_rd_data.blue - r_pixel.blue
                                              : r_pixel.blue - r_rd_data.blue;
    end

    // Sum the squares and compare against the best so far
    always_comb begin
        dist_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
        better   = dist_sum < r_best;
        fin      = r_s2_vld && ((dist_sum == '0) || (r_s2_idx == r_last));
        fin_idx  = better ? r_s2_idx : r_best_idx;
    end

    // Address sweep, square stage, compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            // Finish on exact match or last entry and drop reads in flight
            r_done <= fin;
            if (fin) r_idx <= fin_idx;

            // Start a sweep, or advance the read address up to the last active entry
            if (i_req.start) begin
                r_issue   <= 1'b1;
                r_rd_addr <= '0;
                r_last    <= i_req.last;
                r_pixel   <= i_req.pixel;
            end else if (fin) begin
                r_issue <= 1'b0;
            end else if (r_issue) begin
                if (r_rd_addr == r_last) r_issue <= 1'b0;
                else                     r_rd_addr <= r_rd_addr + 1'b1;
            end

            r_s1_vld <= r_issue && !fin;
            if (r_issue) r_s1_idx <= r_rd_addr;

            r_s2_vld <= r_s1_vld && !fin;
            if (r_s1_vld) begin
                r_s2_idx <= r_s1_idx;
                r_sq_r   <= 16'(d_r) * 16'(d_r);
                r_sq_g   <= 16'(d_g) * 16'(d_g);
                r_sq_b   <= 16'(d_b) * 16'(d_b);
            end

            if (i_req.start) begin
                r_best     <= '1;
                r_best_idx <= '0;
            end else if (r_s2_vld && better) begin
                r_best     <= dist_sum;
                r_best_idx <= r_s2_idx;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.idx  = r_idx;

endmodule
`default_nettype wire

/* rtl/palette_quantize_pack_core.sv */
`default_nettype none
// Channel   Dir  Payload                                        Transfer
// i_pix     in   command, entry_index, red, green, blue, row_end valid & ready
// o_byte    out  packed_byte, row_done                           valid & ready
// APB       in   depth_mode at byte address 0                   psel & penable & pwrite
//
// A pixel searches N palette entries, N being 2, 16 or 256 by depth mode, fewer
// on an exact match: the palette memory port delivers one entry per cycle, then
// squares, compare and pack follow.
// Reset clears the packer, the depth mode (to eight-bit) and the output register;
// the palette stays undefined until written. A full output register stalls the
// pack step of a pixel that emits a byte, and i_pix waits until it drains.
module palette_quantize_pack_core import pqp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pqp_in_if.sink      i_pix,
    pqp_out_if.source   o_byte,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_PACK} t_state;

    t_state           r_state;
    logic [1:0]       r_depth;
    logic [7:0]       r_acc;
    logic [3:0]       r_cnt;
    logic             r_row_end;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic             r_out_row;

    t_search_req req;
    t_search_rsp rsp;

    logic       in_xfer;
    logic       cfg_wr;
    logic       depth_wr;
    logic [2:0] sh;
    logic [7:0] used_raw;
    logic [3:0] used;
    logic [2:0] pos;
    logic [7:0] packed_next;
    logic       emit;
    logic       pack_go;

    assign pready      = 1'b1;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign in_xfer     = i_pix.valid && i_pix.ready;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign depth_wr    = cfg_wr && (paddr[2] == REG_DEPTH_MODE);

    // Read back the depth mode
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DEPTH_MODE) prdata = {30'd0, r_depth};
    end

    // Palette writes within the active depth go straight to memory, pixels start a search
    always_comb begin
        req.wr_en         = in_xfer && (i_pix.command == CMD_WRITE)
                            && ({1'b0, i_pix.entry_index} <= 9'(active_last(r_depth)));
        req.wr_addr       = i_pix.entry_index[IDX_W-1:0];
        req.wr_data.red   = i_pix.red;
        req.wr_data.green = i_pix.green;
        req.wr_data.blue  = i_pix.blue;
        req.start         = in_xfer && (i_pix.command == CMD_PIXEL);
        req.pixel         = req.wr_data;
        req.last          = active_last(r_depth);
    end

    pqp_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Place the index MSB-first behind the bits already used
    always_comb begin
        case (r_depth)
            DEPTH_1B: sh = 3'd0;
            DEPTH_4B: sh = 3'd2;
            default:  sh = 3'd3;
        endcase
        used_raw    = (8'(r_cnt) + 8'd1) << sh;
        used        = (used_raw > 8'd8) ? 4'd8 : used_raw[3:0];
        pos         = 3'(4'd8 - used);
        packed_next = r_acc | (8'(r_idx) << pos);
        emit        = (used == 4'd8) || r_row_end;
        pack_go     = (r_state == ST_PACK) && (!emit || !r_out_vld || o_byte.ready);
    end

    // Collect indices into the partial byte; a depth change drops it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || depth_wr) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (pack_go) begin
            r_acc <= emit ? 8'd0 : packed_next;
            r_cnt <= emit ? 4'd0 : r_cnt + 4'd1;
        end
    end

    // Sequence one item at a time and hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_depth   <= DEPTH_RESET;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (req.start) begin
                        r_row_end <= i_pix.row_end;
                        r_state   <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (rsp.done) begin
                        r_idx   <= rsp.idx;
                        r_state <= ST_PACK;
                    end
                end
                ST_PACK: begin
                    if (pack_go) begin
                        if (emit) begin
                            r_out_byte <= packed_next;
                            r_out_row  <= r_row_end;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // Load the output register on a packed byte, drain it on a transfer
            if (pack_go && emit)                    r_out_vld <= 1'b1;
            else if (o_byte.valid && o_byte.ready) r_out_vld <= 1'b0;

            if (depth_wr) r_depth <= pwdata[1:0];
        end
    end

    assign o_byte.valid       = r_out_vld;
    assign o_byte.packed_byte = r_out_byte;
    assign o_byte.row_done    = r_out_row;

endmodule
`default_nettype wire
